/* src/handle_slot_allocator_core_macros.svh */
// assertion macros for the handle slot allocator core
// expects signals named clock and reset in the including module
`ifndef HANDLE_SLOT_ALLOCATOR_CORE_MACROS_SVH
`define HANDLE_SLOT_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define HSA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HSA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/hsa_pkg.sv */
// shared types and constants for the handle slot allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package hsa_pkg;

   localparam int DEF_SLOTS       = 32;
   localparam int DEF_GROUPS      = 32;
   localparam int DEF_VALUE_WIDTH = 32;

   localparam int CMD_W        = 2;
   localparam int REQ_HANDLE_W = 16;
   localparam int DATA_W       = 32;
   localparam int RSP_HANDLE_W = 10;

   // width of the slice that the find-first-zero unit looks at per cycle
   localparam int CHUNK   = 16;
   localparam int CHUNK_W = 4;

   typedef enum logic [CMD_W-1:0] {
      CMD_TAKE = 2'd0,
      CMD_GIVE = 2'd1,
      CMD_SET  = 2'd2,
      CMD_GET  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic               found;
      logic [CHUNK_W-1:0] pos;
   } ffz_type;

endpackage

`default_nettype wire

/* src/hsa_ffz.sv */
// find-first-zero unit: lowest clear bit of one chunk
// depends on hsa_pkg
`timescale 1ns / 1ps
`default_nettype none

module hsa_ffz
   import hsa_pkg::*;
(
   input  logic [CHUNK-1:0] vec,
   output ffz_type          hit
);

   always_comb begin
      hit.found = ~&vec;
      hit.pos   = '0;
      for (int i = CHUNK - 1; i >= 0; i--) begin
         if (!vec[i]) begin
            hit.pos = CHUNK_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

/* src/handle_slot_allocator_core.sv */
// handle slot allocator: allocation bitmap, value table and command sequencer
// depends on hsa_pkg, hsa_ffz and handle_slot_allocator_core_macros.svh
//
// usage:
//   req channel (valid/ready) carries one command: take, give, set or get,
//   with a handle and a value. rsp channel (valid/ready) returns one result
//   per request: granted handle, read value and an ok flag.
//   the table holds GROUPS*SLOTS handles; the allocation bitmap is kept in
//   rows of at least 16 bits, with a per-row full flag and a per-row
//   written flag in flops, so reset frees every handle without touching the bitmap memory.
//   give, set and get: the sequencer reads the row and value (S_RD), then
//   checks and writes back (S_FIN); no new request is taken until idle.
//   take: the shared 16-bit find-first-zero unit scans the row full flags
//   chunk by chunk (S_SUM), the chosen row is read (S_RD) and scanned chunk
//   by chunk (S_COL), then written back (S_FIN). a full table fails after
//   all summary chunks are scanned.
//   req_ready is high only while the sequencer is idle, also while a
//   result waits in the output register.
//   when a result waits in the output register and rsp_ready is low, the
//   finished result holds in the sequencer and no table write happens until the output register frees up.
//   reset is synchronous, active high: every handle free, no result
//   pending.
`timescale 1ns / 1ps
`default_nettype none
`include "handle_slot_allocator_core_macros.svh"

module handle_slot_allocator_core
   import hsa_pkg::*;
#(
   parameter int SLOTS       = DEF_SLOTS,
   parameter int GROUPS      = DEF_GROUPS,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [CMD_W-1:0]        req_cmd,
   input  logic [REQ_HANDLE_W-1:0] req_handle,
   input  logic [DATA_W-1:0]       req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [RSP_HANDLE_W-1:0] rsp_result_handle,
   output logic [DATA_W-1:0]       rsp_result_value,
   output logic                    rsp_ok
);

   localparam int TABLE      = GROUPS * SLOTS;
   localparam int HW         = $clog2(TABLE);
   localparam int RB         = (HW > 12) ? HW - 8 : CHUNK_W;
   localparam int ROW_W      = 1 << RB;
   localparam int NROWS      = (TABLE + ROW_W - 1) / ROW_W;
   localparam int RW         = (NROWS > 1) ? $clog2(NROWS) : 1;
   localparam int AW         = RW + RB;
   localparam int SUM_CH     = (NROWS + CHUNK - 1) / CHUNK;
   localparam int SUM_W      = SUM_CH * CHUNK;
   localparam int SIW        = (SUM_CH > 1) ? $clog2(SUM_CH) : 1;
   localparam int COL_CH     = ROW_W / CHUNK;
   localparam int CIW        = (COL_CH > 1) ? $clog2(COL_CH) : 1;
   localparam int LAST_VALID = TABLE - (NROWS - 1) * ROW_W;
   localparam logic [ROW_W-1:0] LAST_PAD = ~({ROW_W{1'b1}} >> (ROW_W - LAST_VALID));

   typedef enum logic [2:0] {
      S_IDLE,
      S_SUM,
      S_RD,
      S_COL,
      S_FIN
   } state_type;

   state_type               state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [RW-1:0]           row_ff, row_in;
   logic [RB-1:0]           col_ff, col_in;
   logic                    rng_ff, rng_in;
   logic                    fail_ff, fail_in;
   logic [VALUE_WIDTH-1:0]  val_ff, val_in;
   logic [SIW-1:0]          sidx_ff, sidx_in;
   logic [CIW-1:0]          cidx_ff, cidx_in;
   logic [NROWS-1:0]        rv_ff, rv_in;
   logic [NROWS-1:0]        full_ff, full_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [DATA_W-1:0]       rsp_value_ff, rsp_value_in;
   logic                    rsp_ok_ff, rsp_ok_in;

   logic [ROW_W-1:0]        alloc_mem [NROWS];
   logic [VALUE_WIDTH-1:0]  val_mem [TABLE];
   logic [ROW_W-1:0]        rd_row_ff;
   logic [VALUE_WIDTH-1:0]  rd_val_ff;

   logic [AW-1:0]           req_hnd;
   logic                    req_rng;
   logic [AW-1:0]           hnd_cat;
   logic [HW-1:0]           vaddr;
   logic [ROW_W-1:0]        row_def;
   logic [ROW_W-1:0]        row_word;
   logic [ROW_W-1:0]        col_bit;
   logic [ROW_W-1:0]        new_row;
   logic                    live;
   logic [SUM_W-1:0]        sum_pad;
   logic [CHUNK-1:0]        ffz_vec;
   ffz_type                 ffz_hit;
   logic                    out_free;
   logic                    commit;
   logic                    rd_en;
   logic                    row_we;
   logic                    val_we;
   logic [VALUE_WIDTH-1:0]  val_wd;

   // table lookup helpers
   assign req_hnd  = AW'(req_handle);
   assign req_rng  = ({1'b0, req_handle} < (REQ_HANDLE_W + 1)'(TABLE));
   assign hnd_cat  = {row_ff, col_ff};
   assign vaddr    = hnd_cat[HW-1:0];
   assign row_def  = (row_ff == RW'(NROWS - 1)) ? LAST_PAD : '0;
   assign row_word = rv_ff[row_ff] ? rd_row_ff : row_def;
   assign col_bit  = {{(ROW_W-1){1'b0}}, 1'b1} << col_ff;
   assign new_row  = (cmd_ff == CMD_TAKE) ? (row_word | col_bit) : (row_word & ~col_bit);
   assign live     = rng_ff && row_word[col_ff];

   always_comb begin
      sum_pad = '1;
      sum_pad[NROWS-1:0] = full_ff;
   end

   // one shared search unit for the summary scan and the row scan
   assign ffz_vec = (state_ff == S_SUM) ? sum_pad[sidx_ff*CHUNK +: CHUNK]
                                        : row_word[cidx_ff*CHUNK +: CHUNK];

   hsa_ffz u_ffz (
      .vec (ffz_vec),
      .hit (ffz_hit)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign commit   = (state_ff == S_FIN) && out_free;
   assign rd_en    = (state_ff == S_RD) && rng_ff;

   always_comb begin
      row_we = 1'b0;
      val_we = 1'b0;
      val_wd = val_ff;
      if (commit) begin
         case (cmd_ff)
            CMD_TAKE: begin
               row_we = !fail_ff;
               val_we = !fail_ff;
               val_wd = '1;
            end
            CMD_GIVE: begin
               row_we = live;
            end
            CMD_SET: begin
               val_we = live;
            end
            default: begin
            end
         endcase
      end
   end

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      rng_in        = rng_ff;
      fail_in       = fail_ff;
      val_in        = val_ff;
      sidx_in       = sidx_ff;
      cidx_in       = cidx_ff;
      rv_in         = rv_ff;
      full_in       = full_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_handle_in = rsp_handle_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_ok_in     = rsp_ok_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in  = cmd_type'(req_cmd);
               row_in  = req_hnd[AW-1:RB];
               col_in  = req_hnd[RB-1:0];
               val_in  = VALUE_WIDTH'(req_value);
               fail_in = 1'b0;
               sidx_in = '0;
               if (cmd_type'(req_cmd) == CMD_TAKE) begin
                  rng_in   = 1'b1;
                  state_in = S_SUM;
               end else begin
                  rng_in   = req_rng;
                  state_in = S_RD;
               end
            end
         end
         S_SUM: begin
            if (ffz_hit.found) begin
               row_in   = RW'({sidx_ff, ffz_hit.pos});
               state_in = S_RD;
            end else if (sidx_ff == SIW'(SUM_CH - 1)) begin
               fail_in  = 1'b1;
               state_in = S_FIN;
            end else begin
               sidx_in = sidx_ff + 1'b1;
            end
         end
         S_RD: begin
            cidx_in  = '0;
            state_in = (cmd_ff == CMD_TAKE) ? S_COL : S_FIN;
         end
         S_COL: begin
            if (ffz_hit.found) begin
               col_in   = RB'({cidx_ff, ffz_hit.pos});
               state_in = S_FIN;
            end else begin
               cidx_in = cidx_ff + 1'b1;
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_handle_in = '0;
               rsp_value_in  = '0;
               if (cmd_ff == CMD_TAKE) begin
                  rsp_ok_in = !fail_ff;
                  if (!fail_ff) begin
                     rsp_handle_in = RSP_HANDLE_W'(hnd_cat);
                  end
               end else begin
                  rsp_ok_in = live;
                  if (cmd_ff == CMD_GET && live) begin
                     rsp_value_in = DATA_W'(rd_val_ff);
                  end
               end
               if (row_we) begin
                  rv_in[row_ff]   = 1'b1;
                  full_in[row_ff] = &new_row;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rv_ff        <= '0;
         full_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rv_ff        <= rv_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      rng_ff        <= rng_in;
      fail_ff       <= fail_in;
      val_ff        <= val_in;
      sidx_ff       <= sidx_in;
      cidx_ff       <= cidx_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_ok_ff     <= rsp_ok_in;
   end

   // bitmap rows and bound values
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_row_ff <= alloc_mem[row_ff];
         rd_val_ff <= val_mem[vaddr];
      end
      if (row_we) begin
         alloc_mem[row_ff] <= new_row;
      end
      if (val_we) begin
         val_mem[vaddr] <= val_wd;
      end
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_handle = rsp_handle_ff;
   assign rsp_result_value  = rsp_value_ff;
   assign rsp_ok            = rsp_ok_ff;

   `HSA_ASSERT_NOW(a_col_scan_row_not_full, state_ff == S_COL, !full_ff[row_ff], "row scan on a full row")
   `HSA_ASSERT_NOW(a_sum_only_take, state_ff == S_SUM, cmd_ff == CMD_TAKE, "summary scan outside take")
   `HSA_ASSERT_NOW(a_handle_implies_ok, rsp_valid_ff && rsp_handle_ff != '0, rsp_ok_ff, "handle without ok")
   `HSA_ASSERT_NEXT(a_take_marks_row, commit && cmd_ff == CMD_TAKE && !fail_ff, rv_ff[$past(row_ff)], "take left row unmarked")

endmodule

`default_nettype wire
